>>> hdl/roeol_pkg.sv
// shared types and constants for the ring of entries offset lookup
// no dependencies; imported by roeol_cell and ring_of_entries_offset_lookup
`timescale 1ns / 1ps

package roeol_pkg;

    // widths fixed by the item fields
    localparam int HANDLE_W = 32;
    localparam int LEN_W    = 16;
    localparam int OFS_W    = 20;
    localparam int HSLOT_W  = 4;
    // remaining-record count, wide enough for the largest ring (256)
    localparam int CNT_W    = 9;

    localparam int IN_DATA_W  = 72;   // 68 bits of fields, padded to bytes
    localparam int OUT_DATA_W = 88;   // 86 bits of fields, padded to bytes

    // command codes carried in tuser
    typedef enum logic {
        CMD_ADD  = 1'b0,
        CMD_FIND = 1'b1
    } t_cmd;

    // token walking along the row of cells
    typedef struct packed {
        logic                valid;
        logic                is_add;
        logic                disp;     // add: ring was full, report old handle
        logic [HANDLE_W-1:0] handle;   // add: new handle
        logic [OFS_W-1:0]    rem;      // find: offset left; add: length in low bits
        logic [CNT_W-1:0]    cnt;      // find: records still to visit
    } t_tok;

    // result from a cell, zero unless done
    typedef struct packed {
        logic                done;
        logic                hit;
        logic [HSLOT_W-1:0]  hit_slot;
        logic [HANDLE_W-1:0] hit_handle;
        logic [LEN_W-1:0]    offset_within;
        logic                displaced;
        logic [HANDLE_W-1:0] displaced_handle;
    } t_res;

endpackage

>>> hdl/ring_of_entries_offset_lookup.sv
// top level: overwriting ring of records with byte-offset search
// result path: token register in the target cell, then r_res, then the output register
// one beat in flight; the next is taken once the last result is in the output register
// the walk length is set by the token stepping through the row of slot cells
// reset (synchronous, active low) empties the ring; record contents stay undefined
// depends on roeol_pkg and roeol_cell
`timescale 1ns / 1ps

module ring_of_entries_offset_lookup import roeol_pkg::*; #(
    parameter int SLOTS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave side
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // tdata: record_handle[31:0], record_length[47:32], query_offset[67:48], zero pad
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // tuser: cmd
    input  logic                  i_s_axis_tuser,
    // master side
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // tdata: hit[0], hit_slot[4:1], hit_handle[36:5], offset_within[52:37],
    //        displaced[53], displaced_handle[85:54], zero pad
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    localparam int SLOT_W = $clog2(SLOTS);

    // ring pointers
    logic [SLOT_W-1:0] r_wr;
    logic [SLOT_W-1:0] r_rd;
    logic              r_full;

    // control
    logic              r_busy;     // token out in the row of cells
    logic              r_pend;     // finished result waiting for the output register
    t_res              r_res;
    logic              r_m_tvalid;
    logic [OUT_DATA_W-1:0] r_m_tdata;

    // unpacked input beat
    logic                take;
    t_cmd                in_cmd;
    logic [HANDLE_W-1:0] in_handle;
    logic [LEN_W-1:0]    in_len;
    logic [OFS_W-1:0]    in_ofs;

    logic [SLOT_W-1:0]   wr_nx;
    logic [SLOT_W-1:0]   rd_nx;
    logic [CNT_W-1:0]    used;
    logic [SLOT_W-1:0]   target;
    t_tok                inj_tok;

    t_tok tok_in  [SLOTS];
    t_tok tok_out [SLOTS];
    t_res res     [SLOTS];
    t_res res_any;

    assign in_cmd    = t_cmd'(i_s_axis_tuser);
    assign in_handle = i_s_axis_tdata[HANDLE_W-1:0];
    assign in_len    = i_s_axis_tdata[HANDLE_W+LEN_W-1:HANDLE_W];
    assign in_ofs    = i_s_axis_tdata[HANDLE_W+LEN_W+OFS_W-1:HANDLE_W+LEN_W];

    assign o_s_axis_tready = !r_busy && !r_pend;
    assign take            = i_s_axis_tvalid && o_s_axis_tready;

    assign wr_nx = (r_wr == SLOT_W'(SLOTS - 1)) ? '0 : r_wr + SLOT_W'(1);
    assign rd_nx = (r_rd == SLOT_W'(SLOTS - 1)) ? '0 : r_rd + SLOT_W'(1);

    // number of stored records
    always_comb begin
        if (r_full) begin
            used = CNT_W'(SLOTS);
        end else if (r_wr >= r_rd) begin
            used = CNT_W'(r_wr) - CNT_W'(r_rd);
        end else begin
            used = CNT_W'(r_wr) + CNT_W'(SLOTS) - CNT_W'(r_rd);
        end
    end

    // token for the accepted beat: an add goes to the write slot, a find starts at the oldest
    always_comb begin
        inj_tok        = '0;
        inj_tok.valid  = take;
        inj_tok.is_add = (in_cmd == CMD_ADD);
        if (in_cmd == CMD_ADD) begin
            inj_tok.disp   = r_full;
            inj_tok.handle = in_handle;
            inj_tok.rem    = {{(OFS_W - LEN_W){1'b0}}, in_len};
            target         = r_wr;
        end else begin
            inj_tok.rem = in_ofs;
            inj_tok.cnt = used;
            target      = r_rd;
        end
    end

    // the row of cells, closed into a ring
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        localparam int PREV = (g == 0) ? SLOTS - 1 : g - 1;

        assign tok_in[g] = (take && target == SLOT_W'(g)) ? inj_tok : tok_out[PREV];

        roeol_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (tok_in[g]),
            .o_tok   (tok_out[g]),
            .o_res   (res[g])
        );
    end

    // only the cell holding the token drives a non-zero result
    always_comb begin
        res_any = '0;
        for (int i = 0; i < SLOTS; i++) begin
            res_any = res_any | res[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr       <= '0;
            r_rd       <= '0;
            r_full     <= 1'b0;
            r_busy     <= 1'b0;
            r_pend     <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (take) begin
                r_busy <= 1'b1;
                if (in_cmd == CMD_ADD) begin
                    r_wr <= wr_nx;
                    if (r_full) begin
                        r_rd <= rd_nx;
                    end
                    r_full <= (wr_nx == (r_full ? rd_nx : r_rd));
                end
            end

            if (res_any.done) begin
                r_busy <= 1'b0;
                r_pend <= 1'b1;
            end

            // output register: load a waiting result once the previous beat is gone
            if (!r_m_tvalid || i_m_axis_tready) begin
                r_m_tvalid <= r_pend;
                if (r_pend) begin
                    r_pend <= 1'b0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (res_any.done) begin
            r_res <= res_any;
        end
        if (r_pend && (!r_m_tvalid || i_m_axis_tready)) begin
            r_m_tdata <= {2'b00, r_res.displaced_handle, r_res.displaced,
                          r_res.offset_within, r_res.hit_handle, r_res.hit_slot,
                          r_res.hit};
        end
    end

    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = r_m_tdata;

endmodule

>>> hdl/roeol_cell.sv
// one ring slot: holds a record and handles the token passing through it
// depends on roeol_pkg
`timescale 1ns / 1ps

module roeol_cell import roeol_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_tok i_tok,
    output t_tok o_tok,
    output t_res o_res
);

    localparam int IDX_CODE_W = (IDX > 0) ? $clog2(IDX + 1) + HSLOT_W : HSLOT_W;
    localparam logic [IDX_CODE_W-1:0] IDX_CODE = IDX_CODE_W'(IDX);

    t_tok                r_tok;
    logic [HANDLE_W-1:0] r_handle;
    logic [LEN_W-1:0]    r_len;
    logic                n_wr;
    logic [OFS_W-1:0]    len_ext;

    assign len_ext = {{(OFS_W - LEN_W){1'b0}}, r_len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_wr) begin
            r_handle <= r_tok.handle;
            r_len    <= r_tok.rem[LEN_W-1:0];
        end
    end

    always_comb begin
        o_tok = '0;
        o_res = '0;
        n_wr  = 1'b0;
        if (r_tok.valid) begin
            if (r_tok.is_add) begin
                n_wr                   = 1'b1;
                o_res.done             = 1'b1;
                o_res.displaced        = r_tok.disp;
                o_res.displaced_handle = r_tok.disp ? r_handle : '0;
            end else if (r_tok.cnt == '0) begin
                o_res.done = 1'b1;              // walked past the newest record
            end else if (r_tok.rem < len_ext) begin
                o_res.done          = 1'b1;
                o_res.hit           = 1'b1;
                o_res.hit_slot      = IDX_CODE[HSLOT_W-1:0];
                o_res.hit_handle    = r_handle;
                o_res.offset_within = r_tok.rem[LEN_W-1:0];
            end else begin
                o_tok     = r_tok;
                o_tok.rem = r_tok.rem - len_ext;
                o_tok.cnt = r_tok.cnt - CNT_W'(1);
            end
        end
    end

endmodule
